FILE: src/mrd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response deframer.
package mrd_pkg;

   localparam int MRD_MAX_FRAME_BYTES = 260;
   localparam int MRD_QUEUE_DEPTH     = 2;

   localparam int LEN_W = 9;

   localparam logic [LEN_W-1:0] CAP_RESET      = 9'd256;
   localparam logic [LEN_W-1:0] LEN_OVERHEAD   = 9'd5;
   localparam logic [LEN_W-1:0] FIXED_LEN      = 9'd8;
   localparam logic [LEN_W-1:0] HDR_LAST_POS   = 9'd2;
   localparam logic [LEN_W-1:0] FC_POS         = 9'd1;
   localparam logic [LEN_W-1:0] BODY_FIRST_POS = 9'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_LSB  = 16'h0001;

   // function codes
   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
   localparam logic [7:0] FC_MASK_WRITE    = 8'd22;
   localparam logic [7:0] FC_READ_WRITE    = 8'd23;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PAYLOAD = 2'd1,
      EV_ACCEPT  = 2'd2,
      EV_REJECT  = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_CODE  = 3'd1,
      ERR_LONG  = 3'd2,
      ERR_CRC   = 3'd3,
      ERR_ABORT = 3'd4
   } error_code_type;

   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_ABORT = 1'b1
   } command_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic       is_abort;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     payload_byte;
      logic [7:0]     payload_count;
      error_code_type error_code;
   } result_type;

   // reflected CRC-16, one byte, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_LSB) != 16'h0000) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: src/mrd_fifo.sv
// Small flip-flop queue with full/empty flags, used between the deframer stages.
module mrd_fifo
   import mrd_pkg::*;
#(
   parameter int WIDTH = 9,
   parameter int DEPTH = MRD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + ADDR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + ADDR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/mrd_front.sv
// Front stage: takes requests, classifies byte versus abort, hands them to the queue.
module mrd_front
   import mrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_command,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       q_push,
   output item_type   q_item,
   input  logic       q_full
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take, drain;

   assign drain    = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_push   = valid_ff;
   assign q_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.is_abort <= (command_type'(req_command) == CMD_ABORT);
         item_ff.data     <= req_rx_byte;
      end
   end

endmodule

FILE: src/mrd_back.sv
// Back stage: frame state machine, length rule, CRC-16 check and result generation.
module mrd_back
   import mrd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MRD_MAX_FRAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cap_write,
   input  logic [LEN_W-1:0] cap_value,
   input  logic             in_empty,
   input  item_type         in_item,
   output logic             in_pop,
   input  logic             out_full,
   output logic             out_push,
   output result_type       out_result
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_SKIP   = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       fc_ff, fc_in;
   logic [15:0]      crc_ff, crc_in;
   logic [LEN_W-1:0] cap_ff;

   logic             fire;
   logic [15:0]      crc_next;
   logic [LEN_W-1:0] limit;
   logic [LEN_W-1:0] hdr_len;
   logic             fc_known;
   logic [LEN_W:0]   pos_ext;
   logic [LEN_W:0]   len_ext;
   result_type       res;

   assign fire       = !in_empty && !out_full;
   assign in_pop     = fire;
   assign out_push   = fire;
   assign out_result = res;

   assign crc_next = crc_byte(crc_ff, in_item.data);
   assign limit    = (cap_ff > MAX_LEN) ? MAX_LEN : cap_ff;
   assign pos_ext  = {1'b0, pos_ff};
   assign len_ext  = {1'b0, len_ff};

   always_comb begin
      fc_known = 1'b1;
      if (fc_ff inside {FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
                        FC_READ_INPUT, FC_READ_WRITE}) begin
         hdr_len = {1'b0, in_item.data} + LEN_OVERHEAD;
      end else if (fc_ff inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS,
                                 FC_WRITE_REGS, FC_MASK_WRITE}) begin
         hdr_len = FIXED_LEN;
      end else begin
         hdr_len  = FIXED_LEN;
         fc_known = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      fc_in    = fc_ff;
      crc_in   = crc_ff;
      res      = '{event_kind: EV_NONE, payload_byte: 8'h00,
                   payload_count: 8'h00, error_code: ERR_NONE};

      if (in_item.is_abort) begin
         // report a frame cut short, then return to idle
         if (phase_ff == PH_BODY || (phase_ff == PH_HEADER && pos_ff != '0)) begin
            res.event_kind = EV_REJECT;
            res.error_code = ERR_ABORT;
         end
         phase_in = PH_HEADER;
         pos_in   = '0;
         len_in   = '0;
         fc_in    = '0;
         crc_in   = CRC_INIT;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               crc_in = crc_next;
               if (pos_ff == FC_POS) begin
                  fc_in = in_item.data;
               end
               if (pos_ff < HDR_LAST_POS) begin
                  pos_in = pos_ff + LEN_W'(1);
               end else if (!fc_known) begin
                  phase_in       = PH_SKIP;
                  res.event_kind = EV_REJECT;
                  res.error_code = ERR_CODE;
               end else if (hdr_len > limit) begin
                  phase_in       = PH_SKIP;
                  res.event_kind = EV_REJECT;
                  res.error_code = ERR_LONG;
               end else begin
                  len_in   = hdr_len;
                  pos_in   = BODY_FIRST_POS;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               crc_in = crc_next;
               if (pos_ext + (LEN_W+1)'(1) >= len_ext) begin
                  if (crc_next == 16'h0000) begin
                     res.event_kind    = EV_ACCEPT;
                     res.payload_count = 8'(len_ff - LEN_OVERHEAD);
                     phase_in = PH_HEADER;
                     pos_in   = '0;
                     len_in   = '0;
                     fc_in    = '0;
                     crc_in   = CRC_INIT;
                  end else begin
                     phase_in       = PH_SKIP;
                     res.event_kind = EV_REJECT;
                     res.error_code = ERR_CRC;
                  end
               end else begin
                  if (pos_ext + (LEN_W+1)'(2) < len_ext) begin
                     res.event_kind   = EV_PAYLOAD;
                     res.payload_byte = in_item.data;
                  end
                  pos_in = pos_ff + LEN_W'(1);
               end
            end
            PH_SKIP: begin
               // drop bytes until an abort
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         len_ff   <= '0;
         fc_ff    <= '0;
         crc_ff   <= CRC_INIT;
         cap_ff   <= CAP_RESET;
      end else begin
         if (fire) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            len_ff   <= len_in;
            fc_ff    <= fc_in;
            crc_ff   <= crc_in;
         end
         if (cap_write) begin
            cap_ff <= cap_value;
         end
      end
   end

   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> pos_ff <= HDR_LAST_POS)
      else $error("header position past the byte count");

   a_body_bounds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> (len_ff >= LEN_OVERHEAD && pos_ff < len_ff
                               && len_ff <= MAX_LEN))
      else $error("body position or length out of range");

   a_payload_in_body: assert property (@(posedge clock) disable iff (reset)
      fire && res.event_kind == EV_PAYLOAD |-> phase_ff == PH_BODY && !in_item.is_abort)
      else $error("payload emitted outside a frame body");

   a_accept_idles: assert property (@(posedge clock) disable iff (reset)
      fire && res.event_kind == EV_ACCEPT |=> phase_ff == PH_HEADER && crc_ff == CRC_INIT
                                             && pos_ff == '0)
      else $error("accept did not return to idle");

endmodule

FILE: src/modbus_rtu_response_deframer_top.sv
// A request passes the front stage, item queue, back stage and result queue to the rsp_ ports.
// Throughput: one request per cycle while no queue is full; every request yields exactly one
// result, set by the back stage byte step (CRC-16 update, length rule, frame position).
// Each side stalls on its own through the queues between front, back and result ports.
// Reset (synchronous, active high): queues empty, frame state idle, CRC 0xFFFF, capacity 256.
module modbus_rtu_response_deframer_top
   import mrd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MRD_MAX_FRAME_BYTES,
   parameter int QUEUE_DEPTH     = MRD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       push,
   output logic       full,
   input  logic       req_command,
   input  logic [7:0] req_rx_byte,
   // result side
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_count,
   output logic [2:0] rsp_error_code,
   // capacity register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_buffer_capacity
);

   // front -> queue
   logic       fq_push;
   item_type   fq_item;
   logic       fq_full;
   // queue -> back
   logic       bq_empty;
   logic       bq_pop;
   item_type   bq_item;
   logic [$bits(item_type)-1:0] bq_rdata;
   // back -> result queue
   logic       rq_push;
   logic       rq_full;
   result_type rq_result;
   logic [$bits(result_type)-1:0] rq_rdata;
   result_type rsp;

   // The user must change the register only while the block is idle; writes apply at once.
   assign csr_ready = 1'b1;

   // Front: hold one classified request and advance it into the queue.
   mrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .req_full    (full),
      .q_push      (fq_push),
      .q_item      (fq_item),
      .q_full      (fq_full)
   );

   // Decouple front and back so either can stall without blocking the other.
   mrd_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata (fq_item),
      .full  (fq_full),
      .pop   (bq_pop),
      .rdata (bq_rdata),
      .empty (bq_empty)
   );

   assign bq_item = item_type'(bq_rdata);

   // Back: one byte per cycle through the frame state machine while the result queue has room.
   mrd_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cap_write  (csr_valid && csr_ready),
      .cap_value  (csr_buffer_capacity),
      .in_empty   (bq_empty),
      .in_item    (bq_item),
      .in_pop     (bq_pop),
      .out_full   (rq_full),
      .out_push   (rq_push),
      .out_result (rq_result)
   );

   // Result queue: the oldest result stays on the rsp_ ports until popped.
   mrd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata (rq_result),
      .full  (rq_full),
      .pop   (pop),
      .rdata (rq_rdata),
      .empty (empty)
   );

   assign rsp               = result_type'(rq_rdata);
   assign rsp_event_kind    = rsp.event_kind;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_count = rsp.payload_count;
   assign rsp_error_code    = rsp.error_code;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the Modbus RTU response deframer: directed frames, then random traffic.
module testbench
   import mrd_pkg::*;
();

   localparam int CYCLE_LIMIT    = 200000;
   localparam int MISMATCH_SHOWN = 10;
   localparam int IDLE_PERCENT   = 27;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum logic [1:0] {
      AWAIT_HEADER,
      IN_BODY,
      SKIPPING
   } frame_phase_type;

   // how a directed row gets its byte: literal, abort, or the CRC of the frame so far
   typedef enum logic [2:0] {
      ROW_BYTE,
      ROW_ABORT,
      ROW_CRC_LO,
      ROW_CRC_HI,
      ROW_CRC_BAD
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   data;
      logic         typed;
      result_type   want;
   } stim_row_type;

   // Hold every input at a known value from time zero.
   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       push                = 1'b0;
   logic       req_command         = 1'b0;
   logic [7:0] req_rx_byte         = 8'h00;
   logic       pop                 = 1'b0;
   logic       csr_valid           = 1'b0;
   logic [8:0] csr_buffer_capacity = CAP_RESET;
   logic       full;
   logic       empty;
   logic       csr_ready;
   logic [1:0] rsp_event_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_count;
   logic [2:0] rsp_error_code;

   modbus_rtu_response_deframer_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_command         (req_command),
      .req_rx_byte         (req_rx_byte),
      .empty               (empty),
      .pop                 (pop),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_count   (rsp_payload_count),
      .rsp_error_code      (rsp_error_code),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_buffer_capacity (csr_buffer_capacity)
   );

   // Deframer state as the testbench believes it to be.
   frame_phase_type frame_phase;
   logic [8:0]      frame_pos;
   logic [8:0]      frame_len;
   logic [7:0]      frame_fc;
   logic [15:0]     frame_crc;
   logic [8:0]      frame_capacity;

   result_type      frame_results[$];   // one per accepted request, oldest first
   stim_row_type    directed_rows[$];
   logic [7:0]      frame_bytes[$];
   result_type      oldest_result;
   logic            steady        = 1'b0;  // both sides run flat out while set
   int unsigned     mismatches    = 0;
   int unsigned     cycles        = 0;
   int unsigned     live_requests = 0;    // requests that the block does not just skip

   // ---------------------------------------------------------------------
   // Clock, cycle guard
   // ---------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   // Abandon the run once the cycle count reaches the limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic result_type outcome(event_kind_type ev, logic [7:0] cnt,
                                          error_code_type err);
      result_type r;
      r.event_kind    = ev;
      r.payload_byte  = 8'h00;
      r.payload_count = cnt;
      r.error_code    = err;
      return r;
   endfunction

   // Reflected CRC-16, shifted one bit at a time, LSB first.
   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        lsb;
      c = crc ^ {8'h00, b};
      repeat (8) begin
         lsb = c[0];
         c   = c >> 1;
         if (lsb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_phase = AWAIT_HEADER;
      frame_pos   = '0;
      frame_len   = '0;
      frame_fc    = 8'h00;
      frame_crc   = CRC_INIT;
   endfunction

   // Advance the believed state by one request and return the result it yields.
   function automatic result_type deframe_step(command_type cmd, logic [7:0] b);
      result_type  r;
      int unsigned len;
      int unsigned limit;
      r = outcome(EV_NONE, 8'h00, ERR_NONE);
      if (cmd == CMD_ABORT) begin
         // only a frame that has started and not yet been refused reports the abort
         if (frame_phase == IN_BODY || (frame_phase == AWAIT_HEADER && frame_pos != 0)) begin
            r = outcome(EV_REJECT, 8'h00, ERR_ABORT);
         end
         clear_frame();
         return r;
      end
      if (frame_phase == SKIPPING) begin
         return r;
      end
      frame_crc = crc16_update(frame_crc, b);
      if (frame_phase == AWAIT_HEADER) begin
         if (frame_pos == FC_POS) begin
            frame_fc = b;
         end
         if (frame_pos < HDR_LAST_POS) begin
            frame_pos = frame_pos + 1'b1;
            return r;
         end
         case (frame_fc)
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
            FC_READ_WRITE: begin
               len = b + 5;
            end
            FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS,
            FC_MASK_WRITE: begin
               len = 8;
            end
            default: begin
               frame_phase = SKIPPING;
               return outcome(EV_REJECT, 8'h00, ERR_CODE);
            end
         endcase
         limit = frame_capacity;
         if (limit > MRD_MAX_FRAME_BYTES) begin
            limit = MRD_MAX_FRAME_BYTES;
         end
         if (len > limit) begin
            frame_phase = SKIPPING;
            return outcome(EV_REJECT, 8'h00, ERR_LONG);
         end
         frame_len   = len[8:0];
         frame_pos   = BODY_FIRST_POS;
         frame_phase = IN_BODY;
         return r;
      end
      // body: the last byte closes the frame, the one before it is the first CRC byte
      if (frame_pos + 1 >= frame_len) begin
         if (frame_crc == 16'h0000) begin
            len = frame_len - LEN_OVERHEAD;
            clear_frame();
            r = outcome(EV_ACCEPT, len[7:0], ERR_NONE);
         end else begin
            frame_phase = SKIPPING;
            r = outcome(EV_REJECT, 8'h00, ERR_CRC);
         end
         return r;
      end
      if (frame_pos + 2 < frame_len) begin
         r.event_kind   = EV_PAYLOAD;
         r.payload_byte = b;
      end
      frame_pos = frame_pos + 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Frame building helpers
   // ---------------------------------------------------------------------
   function automatic logic [7:0] random_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [7:0] known_code(int unsigned idx);
      case (idx)
         0:       return FC_READ_COILS;
         1:       return FC_READ_DISCRETE;
         2:       return FC_READ_HOLDING;
         3:       return FC_READ_INPUT;
         4:       return FC_READ_WRITE;
         5:       return FC_WRITE_COIL;
         6:       return FC_WRITE_REG;
         7:       return FC_WRITE_COILS;
         8:       return FC_WRITE_REGS;
         default: return FC_MASK_WRITE;
      endcase
   endfunction

   function automatic logic is_read_code(logic [7:0] fc);
      case (fc)
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_READ_WRITE: return 1'b1;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic logic code_known(logic [7:0] fc);
      for (int i = 0; i < 10; i++) begin
         if (known_code(i) == fc) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void add_row(row_kind_type kind, logic [7:0] data);
      stim_row_type row;
      row.kind  = kind;
      row.data  = data;
      row.typed = 1'b0;
      row.want  = outcome(EV_NONE, 8'h00, ERR_NONE);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(row_kind_type kind, logic [7:0] data, result_type want);
      stim_row_type row;
      row.kind  = kind;
      row.data  = data;
      row.typed = 1'b1;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after the request is taken.
   // Push stays high on return so back-to-back requests need no second assignment.
   task automatic send_request(command_type cmd, logic [7:0] data, logic typed,
                               result_type want);
      result_type got;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= data;
      do @(posedge clock); while (full);
      if (cmd == CMD_ABORT || frame_phase != SKIPPING) begin
         live_requests++;
      end
      got = deframe_step(cmd, data);
      frame_results.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_request(CMD_BYTE, b, 1'b0, outcome(EV_NONE, 8'h00, ERR_NONE));
   endtask

   task automatic send_abort();
      send_request(CMD_ABORT, 8'h00, 1'b0, outcome(EV_NONE, 8'h00, ERR_NONE));
   endtask

   // Build one frame with a proper CRC (or a spoilt one), send it, and resync the
   // line afterwards: stop early once the frame is refused, cut it short on request.
   task automatic send_frame(logic [7:0] fc, logic [7:0] count, logic bad_crc,
                             int unsigned cut);
      logic [15:0] crc;
      int unsigned i;
      int unsigned junk;
      frame_bytes.delete();
      frame_bytes.push_back(random_byte());
      frame_bytes.push_back(fc);
      if (is_read_code(fc)) begin
         frame_bytes.push_back(count);
         repeat (count) frame_bytes.push_back(random_byte());
      end else begin
         repeat (4) frame_bytes.push_back(random_byte());
      end
      crc = CRC_INIT;
      foreach (frame_bytes[k]) begin
         crc = crc16_update(crc, frame_bytes[k]);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(bad_crc ? crc[15:8] ^ (random_byte() | 8'h01) : crc[15:8]);
      i = 0;
      while (i < frame_bytes.size() && (cut == 0 || i < cut) && frame_phase != SKIPPING) begin
         send_byte(frame_bytes[i]);
         i++;
      end
      if (cut != 0) begin
         send_abort();
      end else if (frame_phase == SKIPPING) begin
         // trail a few bytes into the skipped remainder, then clear the line
         junk = $urandom_range(0, 3);
         repeat (junk) send_byte(random_byte());
         send_abort();
      end else if ($urandom_range(0, 9) == 0) begin
         send_abort();
      end
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned cut;
      int unsigned n;
      logic [7:0]  fc;
      logic [7:0]  count;
      logic [31:0] r;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         do fc = random_byte(); while (code_known(fc));
      end else begin
         fc = known_code($urandom_range(0, 9));
      end
      // mostly short frames, now and then a long one right up to the top count
      if ($urandom_range(0, 29) == 0) begin
         count = ($urandom_range(0, 3) == 0) ? 8'hFF : random_byte();
      end else begin
         r     = $urandom_range(0, 12);
         count = r[7:0];
      end
      cut = (pick >= 20 && pick < 32) ? $urandom_range(1, 10) : 0;
      if (pick >= 32 && pick < 38) begin
         // line noise: stray bytes and aborts, then a clean abort
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               send_abort();
            end else begin
               send_byte(random_byte());
            end
         end
         send_abort();
      end else begin
         send_frame(fc, count, pick >= 8 && pick < 20, cut);
      end
   endtask

   task automatic run_random(int unsigned quota);
      live_requests = 0;
      while (live_requests < quota) begin
         send_random_frame();
      end
   endtask

   // Drop push, let every outstanding result arrive, then write the capacity.
   task automatic settle_and_write(logic [8:0] value);
      push <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_buffer_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      frame_capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   // Stall the result side at random unless a steady stretch is running.
   initial begin
      forever begin
         @(negedge clock);
         pop <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Compare every taken result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (frame_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN) begin
               $display("unexpected result: kind %0d byte %02h count %0d error %0d",
                        rsp_event_kind, rsp_payload_byte, rsp_payload_count, rsp_error_code);
            end
         end else begin
            oldest_result = frame_results.pop_front();
            if (rsp_event_kind !== oldest_result.event_kind ||
                rsp_payload_byte !== oldest_result.payload_byte ||
                rsp_payload_count !== oldest_result.payload_count ||
                rsp_error_code !== oldest_result.error_code) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN) begin
                  $display("mismatch: want %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                           oldest_result.event_kind, oldest_result.payload_byte,
                           oldest_result.payload_count, oldest_result.error_code,
                           rsp_event_kind, rsp_payload_byte, rsp_payload_count,
                           rsp_error_code);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type row;
      logic [7:0]   data;
      logic [15:0]  tx_crc;
      logic [31:0]  r;

      clear_frame();
      frame_capacity = CAP_RESET;

      // Directed frames, run at the reset capacity of 256.
      // abort on an idle line
      add_checked(ROW_ABORT, 8'h00, outcome(EV_NONE, 8'h00, ERR_NONE));
      // read with a zero byte count: no payload, accepted with count 0
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, FC_READ_HOLDING);
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_CRC_LO, 8'h00);
      add_checked(ROW_CRC_HI, 8'h00, outcome(EV_ACCEPT, 8'd0, ERR_NONE));
      // read/write response from the top address with one payload byte
      add_row(ROW_BYTE, 8'hFF);
      add_row(ROW_BYTE, FC_READ_WRITE);
      add_row(ROW_BYTE, 8'h01);
      add_row(ROW_BYTE, 8'hA5);
      add_row(ROW_CRC_LO, 8'h00);
      add_checked(ROW_CRC_HI, 8'h00, outcome(EV_ACCEPT, 8'd1, ERR_NONE));
      // exception response: refused on the third header byte
      add_row(ROW_BYTE, 8'h01);
      add_row(ROW_BYTE, FC_READ_HOLDING | 8'h80);
      add_checked(ROW_BYTE, 8'h02, outcome(EV_REJECT, 8'h00, ERR_CODE));
      add_checked(ROW_ABORT, 8'h00, outcome(EV_NONE, 8'h00, ERR_NONE));
      // 260-byte frame against a 256-byte buffer, then a skipped byte
      add_row(ROW_BYTE, 8'h01);
      add_row(ROW_BYTE, FC_READ_INPUT);
      add_checked(ROW_BYTE, 8'hFF, outcome(EV_REJECT, 8'h00, ERR_LONG));
      add_checked(ROW_BYTE, 8'h00, outcome(EV_NONE, 8'h00, ERR_NONE));
      add_checked(ROW_ABORT, 8'h00, outcome(EV_NONE, 8'h00, ERR_NONE));
      // spoilt CRC on the closing byte
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, FC_READ_HOLDING);
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_CRC_LO, 8'h00);
      add_checked(ROW_CRC_BAD, 8'h00, outcome(EV_REJECT, 8'h00, ERR_CRC));
      add_checked(ROW_ABORT, 8'h00, outcome(EV_NONE, 8'h00, ERR_NONE));
      // abort part way through the header
      add_row(ROW_BYTE, 8'h01);
      add_checked(ROW_ABORT, 8'h00, outcome(EV_REJECT, 8'h00, ERR_ABORT));

      // Hold reset from time zero, release it on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the table; CRC rows take their byte from the frame sent so far.
      tx_crc = CRC_INIT;
      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         case (row.kind)
            ROW_BYTE: begin
               data   = row.data;
               tx_crc = crc16_update(tx_crc, data);
            end
            ROW_CRC_LO:  data = tx_crc[7:0];
            ROW_CRC_HI:  data = tx_crc[15:8];
            ROW_CRC_BAD: data = ~tx_crc[15:8];
            default:     data = 8'h00;
         endcase
         if (row.kind == ROW_CRC_HI || row.kind == ROW_CRC_BAD || row.kind == ROW_ABORT) begin
            tx_crc = CRC_INIT;
         end
         send_request(row.kind == ROW_ABORT ? CMD_ABORT : CMD_BYTE, data, row.typed, row.want);
      end

      // Random phases over a spread of capacities, the extremes among them.
      // Largest buffer: lead with the longest legal frame (count 255).
      settle_and_write(9'd260);
      send_frame(FC_READ_HOLDING, 8'hFF, 1'b0, 0);
      run_random(40);
      // No buffer at all: every header with a known code is refused as too long.
      settle_and_write(9'd0);
      run_random(15);
      // Exactly room for the fixed-length responses.
      settle_and_write(9'd8);
      run_random(30);
      // Long stretch with neither side idling.
      steady <= 1'b1;
      settle_and_write(9'd255);
      run_random(50);
      steady <= 1'b0;
      r = $urandom_range(9, 259);
      settle_and_write(r[8:0]);
      run_random(25);
      // Capacity below the header length.
      settle_and_write(9'd2);
      run_random(10);

      // Drain every outstanding result, then watch for strays.
      push <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
